FILE: sv/ttg_pkg.sv
// Shared types, constants and helper functions of the trapezoidal trajectory generator.
package ttg_pkg;

    // Fixed point format of positions, velocities, rates and times.
    localparam int FRACTION_BITS = 16;

    typedef logic signed [63:0] wide_t;
    typedef logic [63:0] mag_t;

    localparam wide_t ONE = wide_t'(64'd1 << FRACTION_BITS);
    localparam wide_t TWO = wide_t'(64'd2 << FRACTION_BITS);
    localparam mag_t CLIP = 64'd1 << 61;
    localparam wide_t PEAK_LIMIT = wide_t'(64'd1 << (62 - FRACTION_BITS));
    localparam logic [31:0] PEAK_SAT = 32'h8000_0000;
    localparam wide_t S32_MAX = 64'sd2147483647;
    localparam wide_t S32_MIN = -64'sd2147483648;

    // Item commands.
    localparam logic CMD_PLAN = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
    localparam logic [1:0] REG_MAX_ACCEL    = 2'd1;
    localparam logic [1:0] REG_MAX_DECEL    = 2'd2;
    localparam logic [30:0] LIMIT_RESET = 31'(1 << FRACTION_BITS);

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_COAST  = 3'd2,
        PH_DECEL  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // Multiply-divide steps that the sequencer runs.
    typedef enum logic [4:0] {
        OP_STOP, OP_TA, OP_TD, OP_M1, OP_M2, OP_W1, OP_W2, OP_Q,
        OP_TA2, OP_TD2, OP_TV, OP_E1, OP_E2, OP_E3,
        OP_EV_AT, OP_EV_P1, OP_EV_P2, OP_EV_CV, OP_EV_DT, OP_EV_DP
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_ISSUE, ST_WAIT, ST_DECIDE,
        ST_SQRT_ISSUE, ST_SQRT_WAIT, ST_COMMIT, ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MD_IDLE, MD_MUL, MD_RND, MD_CHK, MD_DIV, MD_FIN
    } md_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE, SQ_RUN, SQ_FIN
    } sq_state_t;

    typedef struct packed {
        logic load_in;
        logic md_start;
        logic sqrt_start;
        logic commit;
        logic load_out;
        op_t  op;
    } ttg_cmd_t;

    typedef struct packed {
        logic   md_done;
        logic   sqrt_done;
        logic   is_eval;
        logic   is_triangle;
        phase_t ev_phase;
    } ttg_status_t;

    // Saturate to 32 bits signed.
    function automatic logic signed [31:0] sat32(input wide_t x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = 32'sh7fff_ffff;
        end else if (x < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Clamp a duration to 0 .. 2^31-1.
    function automatic logic [30:0] clamp_time(input wide_t x);
        logic [30:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > S32_MAX) begin
            r = 31'h7fff_ffff;
        end else begin
            r = x[30:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/trapezoidal_trajectory_generator_core.sv
// Top level of the trapezoidal trajectory generator: controller, datapath and ports.
//
//  Channel   Signals                                   Transfer when
//  input     in_valid/in_ready, command, positions...  in_valid && in_ready
//  output    out_valid/out_ready, position, phase...   out_valid && out_ready
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
//  One item at a time. Each step runs on one shared multiply-divide unit (a shift-add
//  multiply, then a restoring division). A plan runs nine steps, a triangular plan
//  thirteen steps plus a square root.
//  Reset sets the limits to 1.0 and clears the stored profile; cfg_ready is held high.
//  A waiting result stalls only the finish of the following item.
module trapezoidal_trajectory_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] target_position,
    input  logic signed [31:0] start_position,
    input  logic signed [31:0] start_velocity,
    input  logic signed [31:0] eval_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position,
    output logic signed [31:0] velocity,
    output logic signed [31:0] acceleration,
    output logic [30:0]        total_time,
    output logic [2:0]         phase,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);
    import ttg_pkg::*;

    ttg_cmd_t    cmd;
    ttg_status_t st;

    assign cfg_ready = 1'b1;

    ttg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ttg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .target_position (target_position),
        .start_position  (start_position),
        .start_velocity  (start_velocity),
        .eval_time       (eval_time),
        .position        (position),
        .velocity        (velocity),
        .acceleration    (acceleration),
        .total_time      (total_time),
        .phase           (phase)
    );

endmodule

FILE: sv/ttg_muldiv.sv
// Sequential rounded multiply-divide unit: round(a*b/c), clipped at 2^61.
module ttg_muldiv (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ttg_pkg::wide_t a,
    input  ttg_pkg::wide_t b,
    input  ttg_pkg::wide_t c,
    output logic          done,
    output ttg_pkg::wide_t result
);
    import ttg_pkg::*;

    md_state_t    state_reg, state_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         neg_reg;
    logic [127:0] ma_reg;
    logic [127:0] prod_reg;
    logic [63:0]  mb_reg;
    mag_t         c_reg;
    mag_t         rem_reg;
    mag_t         lo_reg;
    mag_t         q_reg;

    logic   any_zero;
    logic   c_zero;
    mag_t   rem_sh;
    logic   rem_ge;
    mag_t   q_clip;

    function automatic mag_t mag_of(input wide_t x);
        return x[63] ? mag_t'(-x) : mag_t'(x);
    endfunction

    assign any_zero = (a == 0) || (b == 0);
    assign c_zero   = (c == 0);
    assign rem_sh   = {rem_reg[62:0], lo_reg[63]};
    assign rem_ge   = rem_sh >= c_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state: shift-add multiply, rounding, overflow check, long division.
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    state_next = (any_zero || c_zero) ? MD_FIN : MD_MUL;
                end
            end
            MD_MUL: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = MD_RND;
                end
            end
            MD_RND: state_next = MD_CHK;
            MD_CHK: state_next = (prod_reg[127:64] >= c_reg) ? MD_FIN : MD_DIV;
            MD_DIV: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = MD_FIN;
                end
            end
            MD_FIN:  state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // Datapath of the unit.
    always_ff @(posedge clk) begin
        case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    neg_reg  <= (a[63] ^ b[63]) ^ c[63];
                    ma_reg   <= {64'd0, mag_of(a)};
                    mb_reg   <= mag_of(b);
                    c_reg    <= mag_of(c);
                    prod_reg <= '0;
                    q_reg    <= any_zero ? '0 : CLIP;
                end
            end
            MD_MUL: begin
                if (mb_reg[0]) begin
                    prod_reg <= prod_reg + ma_reg;
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            MD_RND: prod_reg <= prod_reg + {65'd0, c_reg[63:1]};
            MD_CHK: begin
                rem_reg <= prod_reg[127:64];
                lo_reg  <= prod_reg[63:0];
                q_reg   <= CLIP;
            end
            MD_DIV: begin
                rem_reg <= rem_ge ? rem_sh - c_reg : rem_sh;
                q_reg   <= {q_reg[62:0], rem_ge};
                lo_reg  <= lo_reg << 1;
            end
            default: begin
            end
        endcase
    end

    // Outputs: clip and apply the sign.
    always_comb begin
        q_clip = (q_reg > CLIP) ? CLIP : q_reg;
        result = neg_reg ? -wide_t'(q_clip) : wide_t'(q_clip);
        done   = (state_reg == MD_FIN);
    end

endmodule

FILE: sv/ttg_isqrt.sv
// Sequential truncating integer square root, two radicand bits per cycle.
module ttg_isqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ttg_pkg::mag_t radicand,
    output logic          done,
    output logic [31:0]   root
);
    import ttg_pkg::*;

    sq_state_t  state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    mag_t       x_reg;
    mag_t       res_reg;
    mag_t       bit_reg;
    mag_t       trial;

    assign trial = res_reg + bit_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SQ_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state: 32 digit steps.
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = SQ_FIN;
                end
            end
            SQ_FIN:  state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    // One result bit per step.
    always_ff @(posedge clk) begin
        if (state_reg == SQ_IDLE && start) begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (state_reg == SQ_RUN) begin
            if (x_reg >= trial) begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = (state_reg == SQ_FIN);
    assign root = res_reg[31:0];

endmodule

FILE: sv/ttg_datapath.sv
// Datapath: input and limit registers, plan state, operand select and result assembly.
module ttg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ttg_pkg::ttg_cmd_t    cmd,
    output ttg_pkg::ttg_status_t st,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data,
    input  logic                 command,
    input  logic signed [31:0]   target_position,
    input  logic signed [31:0]   start_position,
    input  logic signed [31:0]   start_velocity,
    input  logic signed [31:0]   eval_time,
    output logic signed [31:0]   position,
    output logic signed [31:0]   velocity,
    output logic signed [31:0]   acceleration,
    output logic [30:0]          total_time,
    output logic [2:0]           phase
);
    import ttg_pkg::*;

    // Limit registers.
    logic [30:0] max_vel_reg, max_acc_reg, max_dec_reg;

    // Item registers.
    logic               cmd_reg;
    logic signed [31:0] xf_reg, xi_reg, vi_reg, t_reg;

    // Stored profile.
    logic signed [31:0] s_xi_reg, s_xf_reg, s_vi_reg;
    logic signed [31:0] s_ar_reg, s_cv_reg, s_dr_reg;
    logic [30:0]        ta_dur_reg, tc_dur_reg, td_dur_reg, tf_dur_reg;
    logic signed [31:0] aep_reg;

    // Planning work registers.
    logic               sneg_reg;
    logic               tri_reg;
    logic               big_reg;
    logic signed [31:0] ar_reg, dr_reg, vr_reg;
    wide_t              ta_reg, td_reg, tv_reg, dxmin_reg, w_reg, q_reg;
    wide_t              tmp_a_reg, tmp_b_reg, tmp_c_reg;

    // Output registers.
    logic signed [31:0] pos_reg, vel_reg, acc_reg;
    logic [30:0]        total_reg;
    phase_t             phase_reg;

    // Arithmetic units.
    wide_t       md_a, md_b, md_c, md_res;
    logic        md_done, sq_done;
    logic [31:0] sq_root;
    mag_t        sq_in;

    // Widened views.
    wide_t vm_w, am_w, dm_w, dx_w, vi_w, vr_w, ar_w, dr_w;
    wide_t tt_w, tas_w, tc_w, tf_w;
    wide_t dxs_w;
    logic  sneg_c, flip_c;
    wide_t dxmin_c;
    logic [31:0] pk, pk_neg;
    phase_t ev_phase;
    logic signed [31:0] pos_c, vel_c, acc_c;

    ttg_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .a      (md_a),
        .b      (md_b),
        .c      (md_c),
        .done   (md_done),
        .result (md_res)
    );

    assign sq_in = mag_t'(q_reg) << FRACTION_BITS;

    ttg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    // A limit holding zero counts as one lsb.
    assign vm_w  = (max_vel_reg == 0) ? wide_t'(1) : wide_t'(max_vel_reg);
    assign am_w  = (max_acc_reg == 0) ? wide_t'(1) : wide_t'(max_acc_reg);
    assign dm_w  = (max_dec_reg == 0) ? wide_t'(1) : wide_t'(max_dec_reg);
    assign dx_w  = wide_t'(xf_reg) - wide_t'(xi_reg);
    assign vi_w  = wide_t'(vi_reg);
    assign vr_w  = wide_t'(vr_reg);
    assign ar_w  = wide_t'(ar_reg);
    assign dr_w  = wide_t'(dr_reg);
    assign tt_w  = wide_t'(t_reg);
    assign tas_w = wide_t'(ta_dur_reg);
    assign tc_w  = tas_w + wide_t'(tc_dur_reg);
    assign tf_w  = wide_t'(tf_dur_reg);

    // Direction and rates from the stopping distance.
    always_comb begin
        dxs_w  = vi_reg[31] ? -md_res : md_res;
        sneg_c = (dx_w - dxs_w) < 0;
        flip_c = sneg_c ? (vi_w < -vm_w) : (vi_w > vm_w);
        dxmin_c = tmp_b_reg + md_res;
        pk     = big_reg ? PEAK_SAT : sq_root;
        pk_neg = ~pk + 32'd1;
    end

    // Phase of an eval time.
    always_comb begin
        if (tt_w < 0) begin
            ev_phase = PH_BEFORE;
        end else if (tt_w < tas_w) begin
            ev_phase = PH_ACCEL;
        end else if (tt_w < tc_w) begin
            ev_phase = PH_COAST;
        end else if (tt_w < tf_w) begin
            ev_phase = PH_DECEL;
        end else begin
            ev_phase = PH_DONE;
        end
    end

    // Operand select for each multiply-divide step.
    always_comb begin
        md_a = vi_w;
        md_b = ONE;
        md_c = ONE;
        case (cmd.op)
            OP_STOP: begin md_a = vi_w; md_b = vi_w; md_c = dm_w <<< 1; end
            OP_TA, OP_TA2: begin md_a = vr_w - vi_w; md_b = ONE; md_c = ar_w; end
            OP_TD, OP_TD2: begin md_a = -vr_w; md_b = ONE; md_c = dr_w; end
            OP_M1: begin md_a = ta_reg; md_b = vr_w + vi_w; md_c = TWO; end
            OP_M2: begin md_a = td_reg; md_b = vr_w; md_c = TWO; end
            OP_W1: begin md_a = vi_w; md_b = vi_w; md_c = ONE; end
            OP_W2: begin md_a = ar_w; md_b = dx_w; md_c = ONE; end
            OP_Q: begin md_a = w_reg; md_b = dr_w; md_c = dr_w - ar_w; end
            OP_TV: begin md_a = dx_w - dxmin_reg; md_b = ONE; md_c = vr_w; end
            OP_E1: begin md_a = vi_w; md_b = tas_w; md_c = ONE; end
            OP_E2: begin md_a = ar_w; md_b = tas_w; md_c = ONE; end
            OP_E3: begin md_a = tmp_a_reg; md_b = tas_w; md_c = TWO; end
            OP_EV_AT: begin md_a = wide_t'(s_ar_reg); md_b = tt_w; md_c = ONE; end
            OP_EV_P1: begin md_a = wide_t'(s_vi_reg); md_b = tt_w; md_c = ONE; end
            OP_EV_P2: begin md_a = tmp_a_reg; md_b = tt_w; md_c = TWO; end
            OP_EV_CV: begin md_a = wide_t'(s_cv_reg); md_b = tt_w - tas_w; md_c = ONE; end
            OP_EV_DT: begin md_a = wide_t'(s_dr_reg); md_b = tt_w - tf_w; md_c = ONE; end
            OP_EV_DP: begin md_a = tmp_a_reg; md_b = tt_w - tf_w; md_c = TWO; end
            default: begin md_a = vi_w; md_b = ONE; md_c = ONE; end
        endcase
    end

    // Limit registers and the stored profile.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_vel_reg <= LIMIT_RESET;
            max_acc_reg <= LIMIT_RESET;
            max_dec_reg <= LIMIT_RESET;
            s_xi_reg    <= '0;
            s_xf_reg    <= '0;
            s_vi_reg    <= '0;
            s_ar_reg    <= '0;
            s_cv_reg    <= '0;
            s_dr_reg    <= '0;
            ta_dur_reg  <= '0;
            tc_dur_reg  <= '0;
            td_dur_reg  <= '0;
            tf_dur_reg  <= '0;
            aep_reg     <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_MAX_VELOCITY: max_vel_reg <= cfg_data;
                    REG_MAX_ACCEL:    max_acc_reg <= cfg_data;
                    REG_MAX_DECEL:    max_dec_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.commit) begin
                s_xi_reg   <= xi_reg;
                s_xf_reg   <= xf_reg;
                s_vi_reg   <= vi_reg;
                s_ar_reg   <= ar_reg;
                s_dr_reg   <= dr_reg;
                s_cv_reg   <= vr_reg;
                ta_dur_reg <= clamp_time(ta_reg);
                tc_dur_reg <= clamp_time(tv_reg);
                td_dur_reg <= clamp_time(td_reg);
                tf_dur_reg <= clamp_time(ta_reg + tv_reg + td_reg);
            end
            if (md_done && cmd.op == OP_E3) begin
                aep_reg <= sat32(wide_t'(xi_reg) + tmp_b_reg + md_res);
            end
        end
    end

    // Item capture and step write-back.
    always_ff @(posedge clk) begin
        if (cmd.load_in) begin
            cmd_reg <= command;
            xf_reg  <= target_position;
            xi_reg  <= start_position;
            vi_reg  <= start_velocity;
            t_reg   <= eval_time;
        end
        if (md_done) begin
            case (cmd.op)
                OP_STOP: begin
                    sneg_reg <= sneg_c;
                    ar_reg   <= (sneg_c ^ flip_c) ? 32'(-am_w) : 32'(am_w);
                    dr_reg   <= sneg_c ? 32'(dm_w) : 32'(-dm_w);
                    vr_reg   <= sneg_c ? 32'(-vm_w) : 32'(vm_w);
                end
                OP_TA:  ta_reg <= md_res;
                OP_TD:  td_reg <= md_res;
                OP_M1:  tmp_b_reg <= md_res;
                OP_M2: begin
                    dxmin_reg <= dxmin_c;
                    tri_reg   <= sneg_reg ? (dx_w > dxmin_c) : (dx_w < dxmin_c);
                end
                OP_W1: begin
                    tmp_b_reg <= md_res;
                    tv_reg    <= '0;
                end
                OP_W2:  w_reg <= tmp_b_reg + (md_res <<< 1);
                OP_Q: begin
                    q_reg   <= (md_res < 0) ? wide_t'(0) : md_res;
                    big_reg <= md_res > PEAK_LIMIT;
                end
                OP_TA2: ta_reg <= (md_res < 0) ? wide_t'(0) : md_res;
                OP_TD2: td_reg <= (md_res < 0) ? wide_t'(0) : md_res;
                OP_TV:  tv_reg <= md_res;
                OP_E1:  tmp_b_reg <= md_res;
                OP_E2:  tmp_a_reg <= md_res;
                OP_EV_AT, OP_EV_DT: tmp_a_reg <= md_res;
                OP_EV_P1, OP_EV_CV: tmp_b_reg <= md_res;
                OP_EV_P2, OP_EV_DP: tmp_c_reg <= md_res;
                default: begin
                end
            endcase
        end
        // Peak velocity of a triangular profile.
        if (sq_done) begin
            vr_reg <= sneg_reg ? $signed(pk_neg)
                    : (pk[31] ? 32'sh7fff_ffff : $signed(pk));
        end
        if (cmd.load_out) begin
            pos_reg   <= pos_c;
            vel_reg   <= vel_c;
            acc_reg   <= acc_c;
            total_reg <= tf_dur_reg;
            phase_reg <= (cmd_reg == CMD_EVAL) ? ev_phase : PH_BEFORE;
        end
    end

    // Result assembly for the phase of the eval time.
    always_comb begin
        pos_c = '0;
        vel_c = '0;
        acc_c = '0;
        if (cmd_reg == CMD_EVAL) begin
            case (ev_phase)
                PH_BEFORE: begin
                    pos_c = s_xi_reg;
                    vel_c = s_vi_reg;
                end
                PH_ACCEL: begin
                    pos_c = sat32(wide_t'(s_xi_reg) + tmp_b_reg + tmp_c_reg);
                    vel_c = sat32(wide_t'(s_vi_reg) + tmp_a_reg);
                    acc_c = s_ar_reg;
                end
                PH_COAST: begin
                    pos_c = sat32(wide_t'(aep_reg) + tmp_b_reg);
                    vel_c = s_cv_reg;
                end
                PH_DECEL: begin
                    pos_c = sat32(wide_t'(s_xf_reg) + tmp_c_reg);
                    vel_c = sat32(tmp_a_reg);
                    acc_c = s_dr_reg;
                end
                default: pos_c = s_xf_reg;
            endcase
        end
    end

    // Status to the controller.
    always_comb begin
        st.md_done     = md_done;
        st.sqrt_done   = sq_done;
        st.is_eval     = (cmd_reg == CMD_EVAL);
        st.is_triangle = tri_reg;
        st.ev_phase    = ev_phase;
    end

    assign position     = pos_reg;
    assign velocity     = vel_reg;
    assign acceleration = acc_reg;
    assign total_time   = total_reg;
    assign phase        = phase_reg;

endmodule

FILE: sv/ttg_ctrl.sv
// Controller: sequences the plan and eval steps and runs both handshakes.
module ttg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ttg_pkg::ttg_status_t st,
    output ttg_pkg::ttg_cmd_t    cmd
);
    import ttg_pkg::*;

    ctrl_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic        out_valid_reg, out_valid_next;
    logic        load_out;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_STOP;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and next step.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_ISSUE;
                if (!st.is_eval) begin
                    op_next = OP_STOP;
                end else begin
                    case (st.ev_phase)
                        PH_ACCEL: op_next = OP_EV_AT;
                        PH_COAST: op_next = OP_EV_CV;
                        PH_DECEL: op_next = OP_EV_DT;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (st.md_done) begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_STOP:  op_next = OP_TA;
                        OP_TA:    op_next = OP_TD;
                        OP_TD:    op_next = OP_M1;
                        OP_M1:    op_next = OP_M2;
                        OP_M2:    state_next = ST_DECIDE;
                        OP_W1:    op_next = OP_W2;
                        OP_W2:    op_next = OP_Q;
                        OP_Q:     state_next = ST_SQRT_ISSUE;
                        OP_TA2:   op_next = OP_TD2;
                        OP_TD2:   state_next = ST_COMMIT;
                        OP_TV:    state_next = ST_COMMIT;
                        OP_E1:    op_next = OP_E2;
                        OP_E2:    op_next = OP_E3;
                        OP_EV_AT: op_next = OP_EV_P1;
                        OP_EV_P1: op_next = OP_EV_P2;
                        OP_EV_DT: op_next = OP_EV_DP;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_DECIDE: begin
                state_next = ST_ISSUE;
                op_next    = st.is_triangle ? OP_W1 : OP_TV;
            end
            ST_SQRT_ISSUE: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (st.sqrt_done) begin
                    state_next = ST_ISSUE;
                    op_next    = OP_TA2;
                end
            end
            ST_COMMIT: begin
                state_next = ST_ISSUE;
                op_next    = OP_E1;
            end
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        load_out       = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
        in_ready       = (state_reg == ST_IDLE);
        cmd.load_in    = (state_reg == ST_IDLE) && in_valid;
        cmd.md_start   = (state_reg == ST_ISSUE);
        cmd.sqrt_start = (state_reg == ST_SQRT_ISSUE);
        cmd.commit     = (state_reg == ST_COMMIT);
        cmd.load_out   = load_out;
        cmd.op         = op_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // A step result only arrives while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        st.md_done |-> state_reg == ST_WAIT)
        else $error("multiply-divide result outside a wait");

    assert property (@(posedge clk) disable iff (!rst_n)
        st.sqrt_done |-> state_reg == ST_SQRT_WAIT)
        else $error("square root result outside a wait");

    // An accepted item goes straight to dispatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_DISPATCH)
        else $error("accepted item not dispatched");

    // A loaded result is offered on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("loaded result not presented");

endmodule
